// File: design/rms_peak_envelope_decimator_defines.svh
// Assertion macros for the RMS and peak envelope decimator.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef RMS_PEAK_ENVELOPE_DECIMATOR_DEFINES_SVH
`define RMS_PEAK_ENVELOPE_DECIMATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rpe_pkg.sv
// Shared constants and controller/datapath interface types for the
// RMS and peak envelope decimator. No dependencies.
package rpe_pkg;

  // Field and register widths.
  localparam int SAMPLE_BITS   = 24;
  localparam int LEVEL_BITS    = SAMPLE_BITS - 1;
  localparam int PNUM_BITS     = 12;
  localparam int FRAMES_BITS   = 16;
  localparam int CHAN_REG_BITS = 4;
  localparam int LIMIT_BITS    = 13;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((LEVEL_BITS + PNUM_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAMES   = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_LIMIT    = 2'd2
  } cfg_reg_t;

  // Accumulator and arithmetic.
  localparam int SUM_BITS      = 64;
  localparam int WEIGHT_BITS   = 16;
  localparam logic [WEIGHT_BITS-1:0] W_RMS  = 16'd45875;
  localparam logic [WEIGHT_BITS-1:0] W_PEAK = 16'd19661;
  localparam int DEFAULT_POINTS = 100;

  // Parameter defaults.
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int MAX_POINTS_DEF   = 4096;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // capture the sample magnitude
    logic clear_buf;  // new buffer: clear accumulators and counters
    logic square;     // square the magnitude, update the peak
    logic accum;      // add the square, advance the counters
    logic div_step;   // one step of the mean division
    logic sqrt_step;  // one step of the square root
    logic mul_rms;    // weight the rms value
    logic mul_peak;   // weight the peak value
    logic emit;       // load the output register, close the window
  } rpe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic limit_hit;  // the buffer already has all its points
    logic win_end;    // the sample in progress closes the window
    logic out_busy;   // output register holds an item not taken
  } rpe_status_t;

endpackage

// File: design/rpe_ctrl.sv
// Controller state machine of the envelope decimator: sequences the
// per-sample update and the divide, root and blend at window close. Uses rpe_pkg.
module rpe_ctrl
  import rpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tuser,
  output logic        in_tready,
  input  rpe_status_t status,
  output rpe_cmd_t    cmd
);

  localparam int STEP_W = $clog2(SUM_BITS);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_BITS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SUM_BITS / 2 - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SQUARE, S_ACCUM, S_DIV, S_SQRT, S_MULR, S_MULP, S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.clear_buf = in_tuser;
          cmd.take      = in_tuser || !status.limit_hit;
          if (cmd.take) state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        step_nxt  = '0;
        state_nxt = status.win_end ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == SQRT_LAST) state_nxt = S_MULR;
      end
      S_MULR: begin
        cmd.mul_rms = 1'b1;
        state_nxt   = S_MULP;
      end
      S_MULP: begin
        cmd.mul_peak = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: design/rpe_datapath.sv
// Datapath of the envelope decimator: configuration registers, accumulators,
// counters, shift divider, digit root, weighting and the output register. Uses rpe_pkg.
module rpe_datapath
  import rpe_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  rpe_cmd_t               cmd,
  output rpe_status_t            status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [LEVEL_BITS-1:0]  envelope_level,
  output logic [PNUM_BITS-1:0]   point_number,
  output logic                   final_point
);

  localparam int CCW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHW    = $clog2(MAX_CHANNELS + 1);
  localparam int PCW    = $clog2(MAX_POINTS + 1);
  localparam int CNT_W  = FRAMES_BITS + CHW;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int ROOT_W = SUM_BITS / 2;
  localparam int SREM_W = ROOT_W + 2;
  localparam int PROD_W = WEIGHT_BITS + SAMPLE_BITS;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (WEIGHT_BITS - 1);
  localparam logic [PROD_W-WEIGHT_BITS:0] LEVEL_MAX =
    (PROD_W - WEIGHT_BITS + 1)'((64'd1 << LEVEL_BITS) - 64'd1);

  // Configuration.
  logic [FRAMES_BITS-1:0]   cfg_frames_r;
  logic [CHAN_REG_BITS-1:0] cfg_chans_r;
  logic [LIMIT_BITS-1:0]    cfg_limit_r;

  // Window state.
  logic [SUM_BITS-1:0]    sum_r;
  logic [SAMPLE_BITS-1:0] peak_r;
  logic [FRAMES_BITS-1:0] frame_cnt_r;
  logic [CCW-1:0]         chan_cnt_r;
  logic [PCW-1:0]         pcnt_r;

  // Arithmetic registers.
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SQ_W-1:0]        sq_r;
  logic [CNT_W-1:0]       count_r;
  logic [SUM_BITS-1:0]    quo_r;
  logic [CNT_W-1:0]       drem_r;
  logic [SREM_W-1:0]      srem_r;
  logic [ROOT_W-1:0]      root_r;
  logic [PROD_W-1:0]      prod_rms_r;
  logic [PROD_W-1:0]      prod_peak_r;

  // Output register.
  logic                  out_valid_r;
  logic [LEVEL_BITS-1:0] out_level_r;
  logic [PNUM_BITS-1:0]  out_pnum_r;
  logic                  out_last_r;

  logic [FRAMES_BITS-1:0] frames_eff;
  logic [CHW-1:0]         chans_eff;
  logic [31:0]            chans32;
  logic [31:0]            points32;
  logic                   frame_end;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SUM_BITS:0]      sum_wide;
  logic [SUM_BITS-1:0]    sum_sat;
  logic [CNT_W:0]         div_sh;
  logic [CNT_W:0]         div_diff;
  logic                   div_ge;
  logic [SREM_W:0]        sq_r4;
  logic [SREM_W:0]        sq_trial;
  logic [SREM_W:0]        sq_diff;
  logic                   sq_ge;
  logic [SAMPLE_BITS-1:0] root_sat;
  logic [PROD_W:0]        blend;
  logic [PROD_W-WEIGHT_BITS:0] level_full;
  logic [LEVEL_BITS-1:0]  level_sat;
  logic [31:0]            idx32;

  // Effective register values: zero window acts as one, channels clamp
  // to one..MAX_CHANNELS, zero limit means the default, then clamp.
  always_comb begin
    frames_eff = (cfg_frames_r == '0) ? FRAMES_BITS'(1) : cfg_frames_r;
    chans32 = 32'(cfg_chans_r);
    if (chans32 == 32'd0) chans32 = 32'd1;
    if (chans32 > 32'(MAX_CHANNELS)) chans32 = 32'(MAX_CHANNELS);
    chans_eff = CHW'(chans32);
    points32 = (cfg_limit_r == '0) ? 32'(DEFAULT_POINTS) : 32'(cfg_limit_r);
    if (points32 > 32'(MAX_POINTS)) points32 = 32'(MAX_POINTS);
  end

  // Window and buffer status.
  assign frame_end        = (32'(chan_cnt_r) + 32'd1) >= 32'(chans_eff);
  assign status.win_end   = frame_end && ((32'(frame_cnt_r) + 32'd1) >= 32'(frames_eff));
  assign status.limit_hit = 32'(pcnt_r) >= points32;
  assign status.out_busy  = out_valid_r && !out_tready;

  // Magnitude; full-scale negative maps to 2^(SAMPLE_BITS-1) exactly.
  assign mag = sample_value[SAMPLE_BITS-1] ? (~sample_value + 1'b1) : sample_value;

  // Saturating accumulate.
  assign sum_wide = {1'b0, sum_r} + (SUM_BITS + 1)'(sq_r);
  assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  // One restoring divide step: remainder stays below the count.
  assign div_sh   = {drem_r, quo_r[SUM_BITS-1]};
  assign div_diff = div_sh - {1'b0, count_r};
  assign div_ge   = div_sh >= {1'b0, count_r};

  // One digit of the square root, two radicand bits per step.
  assign sq_r4    = {srem_r[SREM_W-2:0], quo_r[SUM_BITS-1:SUM_BITS-2]};
  assign sq_trial = (SREM_W + 1)'({root_r, 2'b01});
  assign sq_diff  = sq_r4 - sq_trial;
  assign sq_ge    = sq_r4 >= sq_trial;

  // A window shortened mid-way can leave a root above the sample range;
  // clamping it still drives the blended level into saturation.
  assign root_sat = (root_r[ROOT_W-1:SAMPLE_BITS] != '0) ? '1 : root_r[SAMPLE_BITS-1:0];

  // Weighted blend with round half up, saturated.
  assign blend      = (PROD_W + 1)'(prod_rms_r) + (PROD_W + 1)'(prod_peak_r) + ROUND_HALF;
  assign level_full = blend[PROD_W:WEIGHT_BITS];
  assign level_sat  = (level_full > LEVEL_MAX) ? LEVEL_MAX[LEVEL_BITS-1:0]
                                               : level_full[LEVEL_BITS-1:0];
  assign idx32      = 32'(pcnt_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= FRAMES_BITS'(1);
      cfg_chans_r  <= CHAN_REG_BITS'(1);
      cfg_limit_r  <= LIMIT_BITS'(DEFAULT_POINTS);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAMES:   cfg_frames_r <= cfg_wdata[FRAMES_BITS-1:0];
        REG_CHANNELS: cfg_chans_r  <= cfg_wdata[CHAN_REG_BITS-1:0];
        REG_LIMIT:    cfg_limit_r  <= cfg_wdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Accumulators, counters and the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      peak_r      <= '0;
      frame_cnt_r <= '0;
      chan_cnt_r  <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.clear_buf) begin
        sum_r       <= '0;
        peak_r      <= '0;
        frame_cnt_r <= '0;
        chan_cnt_r  <= '0;
        pcnt_r      <= '0;
      end
      if (cmd.square && (mag_r > peak_r)) peak_r <= mag_r;
      if (cmd.accum) begin
        sum_r <= sum_sat;
        if (frame_end) begin
          chan_cnt_r  <= '0;
          frame_cnt_r <= frame_cnt_r + 1'b1;
        end else begin
          chan_cnt_r <= chan_cnt_r + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        peak_r      <= '0;
        frame_cnt_r <= '0;
        chan_cnt_r  <= '0;
        pcnt_r      <= PCW'(idx32 + 32'd1);
      end
    end
  end

  // Arithmetic pipeline registers.
  always_ff @(posedge clk) begin
    if (cmd.take) mag_r <= mag;
    if (cmd.square) sq_r <= SQ_W'(mag_r) * SQ_W'(mag_r);
    // Window close: load the divider and clear the root unit.
    if (cmd.accum && status.win_end) begin
      quo_r   <= sum_sat;
      drem_r  <= '0;
      srem_r  <= '0;
      root_r  <= '0;
      count_r <= CNT_W'(frames_eff) * CNT_W'(chans_eff);
    end
    if (cmd.div_step) begin
      drem_r <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
      quo_r  <= {quo_r[SUM_BITS-2:0], div_ge};
    end
    if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? sq_diff[SREM_W-1:0] : sq_r4[SREM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], sq_ge};
      quo_r  <= {quo_r[SUM_BITS-3:0], 2'b00};
    end
    if (cmd.mul_rms) begin
      prod_rms_r <= PROD_W'(W_RMS) * PROD_W'(root_sat);
    end
    if (cmd.mul_peak) prod_peak_r <= PROD_W'(W_PEAK) * PROD_W'(peak_r);
    if (cmd.emit) begin
      out_level_r <= level_sat;
      out_pnum_r  <= idx32[PNUM_BITS-1:0];
      out_last_r  <= (idx32 + 32'd1) == points32;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign envelope_level = out_level_r;
  assign point_number   = out_pnum_r;
  assign final_point    = out_last_r;

endmodule

// File: design/rms_peak_envelope_decimator.sv
// Top level of the windowed RMS and peak envelope decimator.
// Depends on rpe_pkg, rpe_ctrl and rpe_datapath.
//
// Input channel: one signed sample per item in in_tdata, channels
// interleaved; in_tuser set marks the first sample of a new buffer and
// clears the accumulators and counters before that sample is used.
// Output channel: one overview point per closed window, the blended
// level and its point number in out_tdata, out_tlast on the last point.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index
// (0 frames per window, 1 channel count, 2 point limit); the user must
// write only while idle, the block does not enforce it. A sample passes
// the accept, square and accumulate states, and no new sample is taken
// until it is done; a sample beyond the point limit is taken and dropped.
// A window-closing sample adds 64 divide steps in the shift divider, 32
// digit root steps, the rms and peak weighting and then the emit state.
// Reset clears the configuration to its defaults and the window state.
// A stalled receiver holds the point in the output register; input is
// still taken until the next window closes, which then waits for it.
module rms_peak_envelope_decimator
  import rpe_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Sample input.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [23:0] sample_value
  input  logic                   in_tuser,   // [0] buffer_start
  // Overview point output.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [22:0] envelope_level, [34:23] point_number
  output logic                   out_tlast   // final_point
);

  localparam int OUT_PAD = OUT_TDATA_W - LEVEL_BITS - PNUM_BITS;

  rpe_cmd_t              cmd;
  rpe_status_t           status;
  logic [LEVEL_BITS-1:0] envelope_level;
  logic [PNUM_BITS-1:0]  point_number;

  rpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rpe_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_POINTS   (MAX_POINTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .sample_value   (in_tdata[SAMPLE_BITS-1:0]),
    .cmd            (cmd),
    .status         (status),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .envelope_level (envelope_level),
    .point_number   (point_number),
    .final_point    (out_tlast)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, point_number, envelope_level};

endmodule

// File: design/rpe_checker.sv
// Port-level checker for the envelope decimator, bound to the top level.
// Depends on rpe_pkg and rms_peak_envelope_decimator_defines.svh.
`include "rms_peak_envelope_decimator_defines.svh"

module rpe_checker
  import rpe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A point waiting on the receiver keeps its contents.
  `RPE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output item changed while stalled")

  // A new point is only loaded while the input side is busy.
  `RPE_ASSERT_IMPLY(a_point_while_busy, $rose(out_tvalid), $past(!in_tready), "point appeared while input was open")

  // The first sample of a buffer is always processed, never dropped.
  `RPE_ASSERT_NEXT(a_start_taken, in_tvalid && in_tready && in_tuser, !in_tready, "buffer start item was not processed")

  // Padding bits above the point number stay zero.
  `RPE_ASSERT_IMPLY(a_pad_zero, out_tvalid, out_tdata[OUT_TDATA_W-1:LEVEL_BITS+PNUM_BITS] == '0, "output padding not zero")

endmodule

bind rms_peak_envelope_decimator rpe_checker u_rpe_checker (.*);
